// ----- rtl/core/satg_pkg.sv -----
// Shared types and constants for the synthetic audio test generator.
// No dependencies; every other file in rtl/core imports this package.
package satg_pkg;

    localparam int PHASE_W         = 32;
    localparam int SAMPLE_W        = 16;
    localparam int IDX_W           = 10;
    localparam int SPF_W           = 11;
    localparam int FPL_W           = 8;
    localparam int LEVEL_W         = 4;
    localparam int BASE_W          = 14;
    localparam int STEP_W          = 11;
    localparam int ENV_STEP_W      = STEP_W + LEVEL_W;
    localparam int ENV_W           = 16;
    localparam int ENV3_W          = 15;
    localparam int DIV3_W          = 32;
    localparam int DIV3_SHIFT      = 17;
    localparam int PROD_W          = 33;
    localparam int TERM_W          = 18;
    localparam int NOISE_SH_W      = 11;
    localparam int SUM_W           = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int ENVELOPE_LEVELS = 10;

    localparam logic [PHASE_W-1:0] INC_A_RST     = 32'd5905580;
    localparam logic [PHASE_W-1:0] INC_B_RST     = 32'd9126805;
    localparam logic [BASE_W-1:0]  ENV_BASE_RST  = 14'd5000;
    localparam logic [STEP_W-1:0]  ENV_STEP_RST  = 11'd900;
    localparam logic [SPF_W-1:0]   SPF_RST       = 11'd320;
    localparam logic [FPL_W-1:0]   FPL_RST       = 8'd25;

    localparam logic [PHASE_W-1:0] PHASE_A_RST   = 32'h0000_0000;
    localparam logic [PHASE_W-1:0] PHASE_B_RST   = 32'h1234_5678;
    localparam logic [PHASE_W-1:0] NOISE_RST     = 32'hA5C3_9E17;

    localparam logic [SPF_W-1:0]   SPF_MAX       = 11'd1024;
    localparam logic [ENV_W-1:0]   DIV3_MUL      = 16'd43691;
    localparam logic [LEVEL_W:0]   LEVEL_COUNT   = (LEVEL_W+1)'(ENVELOPE_LEVELS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INC_A    = 3'd0,
        REG_INC_B    = 3'd1,
        REG_ENV_BASE = 3'd2,
        REG_ENV_STEP = 3'd3,
        REG_SPF      = 3'd4,
        REG_FPL      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [PHASE_W-1:0] inc_a;
        logic [PHASE_W-1:0] inc_b;
        logic [BASE_W-1:0]  env_base;
        logic [STEP_W-1:0]  env_step;
        logic [SPF_W-1:0]   spf;
        logic [FPL_W-1:0]   fpl;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] saw_a;
        logic signed [SAMPLE_W-1:0] saw_b;
        logic signed [SAMPLE_W-1:0] noise;
        logic [ENV_W-1:0]           env;
        logic                       last;
    } t_s1;

endpackage

// ----- rtl/core/satg_if.sv -----
// Valid/ready channels of the synthetic audio test generator: tick input,
// sample output and configuration writes. Depends on satg_pkg.
interface satg_item_if ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface satg_sample_if import satg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface satg_cfg_if import satg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/satg_regs.sv -----
// Configuration register file of the synthetic audio test generator.
// Depends on satg_pkg and satg_cfg_if.
module satg_regs import satg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    satg_cfg_if.sink      i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inc_a    <= INC_A_RST;
            r_cfg.inc_b    <= INC_B_RST;
            r_cfg.env_base <= ENV_BASE_RST;
            r_cfg.env_step <= ENV_STEP_RST;
            r_cfg.spf      <= SPF_RST;
            r_cfg.fpl      <= FPL_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_INC_A:    r_cfg.inc_a    <= i_cfg.data;
                REG_INC_B:    r_cfg.inc_b    <= i_cfg.data;
                REG_ENV_BASE: r_cfg.env_base <= i_cfg.data[BASE_W-1:0];
                REG_ENV_STEP: r_cfg.env_step <= i_cfg.data[STEP_W-1:0];
                REG_SPF:      r_cfg.spf      <= i_cfg.data[SPF_W-1:0];
                REG_FPL:      r_cfg.fpl      <= i_cfg.data[FPL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/satg_state.sv -----
// Oscillator, noise and frame/envelope state of the test generator, plus
// the first pipeline register. Depends on satg_pkg and satg_item_if.
module satg_state import satg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    satg_item_if.sink     i_item,
    input  logic          i_s1_ready,
    output logic          o_s1_valid,
    output t_s1           o_s1
);

    logic [PHASE_W-1:0] r_phase_a, r_phase_b, r_noise;
    logic [IDX_W-1:0]   r_idx;
    logic [FPL_W-1:0]   r_fil;
    logic [LEVEL_W-1:0] r_level;
    logic               r_v1;
    t_s1                r_s1;

    logic [PHASE_W-1:0] cur_pa, cur_pb, cur_nw, nw_1, nw_2;
    logic [IDX_W-1:0]   cur_idx;
    logic [FPL_W-1:0]   cur_fil, fil_inc, fpl_eff;
    logic [LEVEL_W-1:0] cur_level;
    logic [SPF_W-1:0]   spf_eff;
    logic [ENV_STEP_W-1:0] env_step;

    logic [PHASE_W-1:0] n_phase_a, n_phase_b, n_noise;
    logic [IDX_W-1:0]   n_idx;
    logic [FPL_W-1:0]   n_fil;
    logic [LEVEL_W-1:0] n_level;
    t_s1                n_s1;
    logic               ready, accept;

    assign ready        = !r_v1 || i_s1_ready;
    assign accept       = i_item.valid && ready;
    assign i_item.ready = ready;
    assign o_s1_valid   = r_v1;
    assign o_s1         = r_s1;

    always_comb begin
        cur_pa    = i_item.restart ? PHASE_A_RST : r_phase_a;
        cur_pb    = i_item.restart ? PHASE_B_RST : r_phase_b;
        cur_nw    = i_item.restart ? NOISE_RST   : r_noise;
        cur_idx   = i_item.restart ? '0 : r_idx;
        cur_fil   = i_item.restart ? '0 : r_fil;
        cur_level = i_item.restart ? '0 : r_level;

        n_phase_a = cur_pa + i_cfg.inc_a;
        n_phase_b = cur_pb + i_cfg.inc_b;
        nw_1      = cur_nw ^ (cur_nw << 13);
        nw_2      = nw_1 ^ (nw_1 >> 17);
        n_noise   = nw_2 ^ (nw_2 << 5);

        if (i_cfg.spf == '0) begin
            spf_eff = SPF_W'(1);
        end else if (i_cfg.spf > SPF_MAX) begin
            spf_eff = SPF_MAX;
        end else begin
            spf_eff = i_cfg.spf;
        end
        fpl_eff = (i_cfg.fpl == '0) ? FPL_W'(1) : i_cfg.fpl;

        n_s1.last = (SPF_W'(cur_idx) + SPF_W'(1)) >= spf_eff;
        fil_inc   = cur_fil + FPL_W'(1);
        n_idx     = cur_idx;
        n_fil     = cur_fil;
        n_level   = cur_level;
        if (n_s1.last) begin
            n_idx = '0;
            if (fil_inc >= fpl_eff) begin
                n_fil = '0;
                if ((LEVEL_W+1)'(cur_level) + (LEVEL_W+1)'(1) >= LEVEL_COUNT) begin
                    n_level = '0;
                end else begin
                    n_level = cur_level + LEVEL_W'(1);
                end
            end else begin
                n_fil = fil_inc;
            end
        end else begin
            n_idx = cur_idx + IDX_W'(1);
        end

        n_s1.saw_a = signed'({~n_phase_a[PHASE_W-1], n_phase_a[PHASE_W-2:PHASE_W-SAMPLE_W]});
        n_s1.saw_b = signed'({~n_phase_b[PHASE_W-1], n_phase_b[PHASE_W-2:PHASE_W-SAMPLE_W]});
        n_s1.noise = signed'(n_noise[SAMPLE_W-1:0]);
        env_step   = ENV_STEP_W'(i_cfg.env_step) * ENV_STEP_W'(cur_level);
        n_s1.env   = ENV_W'(i_cfg.env_base) + ENV_W'(env_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_a <= PHASE_A_RST;
            r_phase_b <= PHASE_B_RST;
            r_noise   <= NOISE_RST;
            r_idx     <= '0;
            r_fil     <= '0;
            r_level   <= '0;
            r_v1      <= 1'b0;
        end else begin
            if (ready) begin
                r_v1 <= i_item.valid;
            end
            if (accept) begin
                r_phase_a <= n_phase_a;
                r_phase_b <= n_phase_b;
                r_noise   <= n_noise;
                r_idx     <= n_idx;
                r_fil     <= n_fil;
                r_level   <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

endmodule

// ----- rtl/core/satg_mix.sv -----
// Envelope scaling, mixing and saturation of the test generator: a multiplier
// stage, then one into the output register. Depends on satg_pkg, satg_sample_if.
module satg_mix import satg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s1_valid,
    input  t_s1           i_s1,
    output logic          o_s1_ready,
    satg_sample_if.source o_sample
);

    logic                       r_v2, r_vo;
    logic signed [TERM_W-1:0]   r2_term_a;
    logic signed [SAMPLE_W-1:0] r2_saw_b;
    logic [ENV3_W-1:0]          r2_env3;
    logic signed [NOISE_SH_W-1:0] r2_noise;
    logic                       r2_last;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_frame_end;

    logic                       en_o, en2;
    logic [DIV3_W-1:0]          div3_prod;
    logic signed [PROD_W-1:0]   saw_a_ext, env_ext, prod_a;
    logic signed [PROD_W-1:0]   saw_b_ext, env3_ext, prod_b;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] n_sample;

    assign en_o       = !r_vo || o_sample.ready;
    assign en2        = !r_v2 || en_o;
    assign o_s1_ready = en2;

    assign o_sample.valid     = r_vo;
    assign o_sample.sample    = r_sample;
    assign o_sample.frame_end = r_frame_end;

    always_comb begin
        div3_prod = DIV3_W'(i_s1.env) * DIV3_W'(DIV3_MUL);
        saw_a_ext = PROD_W'(i_s1.saw_a);
        env_ext   = signed'(PROD_W'(i_s1.env));
        prod_a    = saw_a_ext * env_ext;

        saw_b_ext = PROD_W'(r2_saw_b);
        env3_ext  = signed'(PROD_W'(r2_env3));
        prod_b    = saw_b_ext * env3_ext;

        sum = SUM_W'(r2_term_a) + SUM_W'(signed'(prod_b[TERM_W+14:15]))
            + SUM_W'(r2_noise);

        if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
            n_sample = sum[SAMPLE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            n_sample = signed'({1'b1, {(SAMPLE_W-1){1'b0}}});
        end else begin
            n_sample = signed'({1'b0, {(SAMPLE_W-1){1'b1}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_s1_valid;
            end
            if (en_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && i_s1_valid) begin
            r2_term_a <= prod_a[TERM_W+14:15];
            r2_saw_b  <= i_s1.saw_b;
            r2_env3   <= div3_prod[DIV3_SHIFT+ENV3_W-1:DIV3_SHIFT];
            r2_noise  <= i_s1.noise[SAMPLE_W-1:5];
            r2_last   <= i_s1.last;
        end
        if (en_o && r_v2) begin
            r_sample    <= n_sample;
            r_frame_end <= r2_last;
        end
    end

endmodule

// ----- rtl/core/synthetic_audio_test_generator.sv -----
// Top level of the synthetic audio test generator: config registers, state
// stage and mixing stages. Depends on satg_pkg, satg_if, satg_regs,
// satg_state and satg_mix.
//
// Usage:
//   i_item carries one tick per word; restart=1 reloads phases, noise seed,
//   frame and envelope counters before that tick's sample is formed.
//   o_sample returns one saturated signed 16-bit sample per tick, with
//   frame_end set on the last sample of each frame.
//   i_cfg writes registers 0..5 (increments, envelope base and step, samples
//   per frame, frames per level); its ready is always high. Write only while
//   no tick is in flight.
// Timing:
//   Three register stages (state, first multiplier, output); a sample is
//   registered in each in turn. One tick per cycle is taken while the output
//   is not stalled; the state update with the envelope, the divide by three
//   with the first saw product, and the second saw product with the mix and
//   saturation each take one stage.
// Reset and stall:
//   i_rst_n (synchronous, active low) restores register defaults and the
//   oscillator state and empties the pipeline. When o_sample.ready is low
//   the output word holds; empty stages still fill, then i_item.ready drops.
module synthetic_audio_test_generator import satg_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    satg_cfg_if.sink      i_cfg,
    satg_item_if.sink     i_item,
    satg_sample_if.source o_sample
);

    t_cfg cfg;
    t_s1  s1;
    logic s1_valid, s1_ready;

    satg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    satg_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_item     (i_item),
        .i_s1_ready (s1_ready),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    satg_mix u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s1_ready (s1_ready),
        .o_sample   (o_sample)
    );

endmodule

// ----- rtl/core/satg_checker.sv -----
// Port-level checks for the synthetic audio test generator, bound to the
// top level. Depends on satg_pkg and synthetic_audio_test_generator.
module satg_checker import satg_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_cfg_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic                       i_frame_end
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_sample) && $stable(i_frame_end))
        else $error("stalled output word changed");

    a_in_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> ##2 i_out_valid)
        else $error("accepted tick did not reach output");

endmodule

bind synthetic_audio_test_generator satg_checker u_satg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_sample.valid),
    .i_out_ready (o_sample.ready),
    .i_sample    (o_sample.sample),
    .i_frame_end (o_sample.frame_end)
);
